### rtl/sadb_pkg.sv
// sadb_pkg: shared types for the sorted distinct byte set
// holds the controller state type and the structs passed along the cell row
// no dependencies

package sadb_pkg;

	localparam int unsigned ByteW = 8;

	typedef logic [ByteW-1:0] byte_t;

	typedef enum logic [0:0] {
		ST_COLLECT,
		ST_DRAIN
	} sadb_state_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic  insert;
		logic  shift;
		byte_t value;
	} cell_ctrl_t;

	// what a cell shows its neighbours
	typedef struct packed {
		logic  valid;
		logic  gt;
		byte_t value;
	} cell_link_t;

endpackage

### rtl/sadb_cell.sv
// sadb_cell: one slot of the ascending insertion chain
// depends on sadb_pkg for the control and neighbour link structs

module sadb_cell
	import sadb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  cell_link_t prev,
	input  cell_link_t next,
	output cell_link_t self,
	output logic       hit
);

	byte_t held_q;
	logic  valid_q;
	logic  gt;

	// empty slots count as greater so a new byte lands after the last held one
	assign gt   = !valid_q || (held_q > ctrl.value);
	assign hit  = valid_q && (held_q == ctrl.value);
	assign self = '{valid: valid_q, gt: gt, value: held_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next.valid;
		end else if (ctrl.insert) begin
			valid_q <= valid_q | (gt & prev.valid);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			held_q <= next.value;
		end else if (ctrl.insert && gt) begin
			// first greater slot takes the new byte, later ones move up by one
			held_q <= prev.gt ? prev.value : ctrl.value;
		end
	end

endmodule

### rtl/sort_and_dedup_bytes.sv
// sort_and_dedup_bytes: top level of the sorted distinct byte set
// depends on sadb_pkg and sadb_cell
//
// channel | dir | handshake               | contents
// --------+-----+-------------------------+---------------------------------------
// s_axis  | in  | s_axis_tvalid/tready    | tdata char_value, tlast end_of_set
// m_axis  | out | m_axis_tvalid/tready    | tdata sorted_char, tlast last_char,
//         |     |                         | tuser overflow_flag
//
// one input word is taken per cycle while collecting; the new byte is placed
// into the cell row in the same cycle it is accepted
// after the word marked tlast the row drains one held byte per cycle to m_axis,
// paced by m_axis_tready
// s_axis_tready is low for the whole drain
// reset clears the valid bits of all cells, the overflow bit and the controller
// a stall on m_axis simply holds the row; the front cell is the output register

module sort_and_dedup_bytes
	import sadb_pkg::*;
#(
	parameter int unsigned ITEMS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] char_value
	input  logic       s_axis_tlast,  // end_of_set
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] sorted_char
	output logic       m_axis_tlast,  // last_char
	output logic       m_axis_tuser   // [0] overflow_flag
);

	sadb_state_t state_q, state_d;
	logic        overflow_q;
	cell_ctrl_t  ctrl;
	cell_link_t  links [ITEMS];
	logic [ITEMS-1:0] hits;
	logic        in_acc;
	logic        out_acc;
	logic        dup;
	logic        full;
	logic        drain_last;

	assign in_acc     = s_axis_tvalid && s_axis_tready;
	assign out_acc    = m_axis_tvalid && m_axis_tready;
	assign dup        = |hits;
	// row fills from the front, so the back cell being valid means full
	assign full       = links[ITEMS-1].valid;
	// ascending order: when the second cell is empty the front one is the last byte
	assign drain_last = !links[1].valid;

	assign ctrl.value  = s_axis_tdata;
	assign ctrl.insert = in_acc && !dup && !full;
	assign ctrl.shift  = out_acc;

	// cell row, lowest byte at the front
	for (genvar i = 0; i < ITEMS; i++) begin : g_cell
		cell_link_t prev_link;
		cell_link_t next_link;

		if (i == 0) begin : g_head
			assign prev_link = '{valid: 1'b1, gt: 1'b0, value: '0};
		end else begin : g_prev
			assign prev_link = links[i-1];
		end

		if (i == ITEMS - 1) begin : g_tail
			assign next_link = '{valid: 1'b0, gt: 1'b1, value: '0};
		end else begin : g_next
			assign next_link = links[i+1];
		end

		sadb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.prev   (prev_link),
			.next   (next_link),
			.self   (links[i]),
			.hit    (hits[i])
		);
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		case (state_q)
			ST_COLLECT: begin
				s_axis_tready = 1'b1;
				if (in_acc && s_axis_tlast) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				m_axis_tvalid = 1'b1;
				if (out_acc && drain_last) begin
					state_d = ST_COLLECT;
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	// sticky overflow, reported on every word of the set and cleared after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q <= 1'b0;
		end else if (out_acc && drain_last) begin
			overflow_q <= 1'b0;
		end else if (in_acc && !dup && full) begin
			overflow_q <= 1'b1;
		end
	end

	assign m_axis_tdata = links[0].value;
	assign m_axis_tlast = drain_last;
	assign m_axis_tuser = overflow_q;

	// checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input and output open together");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !m_axis_tlast) |=> (m_axis_tvalid && (m_axis_tdata > $past(m_axis_tdata))))
		else $error("drained words not strictly ascending");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tlast) |=> m_axis_tvalid)
		else $error("no output after end of set");

	a_back_to_collect: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_axis_tlast) |=> (s_axis_tready && !overflow_q))
		else $error("not ready for a new set after the last word");

	a_front_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> links[0].valid)
		else $error("draining an empty row");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for sort_and_dedup_bytes, directed and random byte sets
// predicts each sorted, deduplicated set and scoreboards every m_axis word
// depends on sadb_pkg and the sort_and_dedup_bytes rtl

module tb;
	import sadb_pkg::*;

	localparam int unsigned SET_CAP = 8;

	typedef struct packed {
		byte_t sorted_char;
		logic  last_char;
		logic  overflow_flag;
	} sorted_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;  // [7:0] char_value
	logic        s_axis_tlast;  // end_of_set
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;  // [7:0] sorted_char
	logic        m_axis_tlast;  // last_char
	logic        m_axis_tuser;  // [0] overflow_flag

	// predicted state of the set being collected
	byte_t        held_bytes [SET_CAP];
	int unsigned  held_n;
	bit           held_ovf;

	sorted_word_t expected_words [$];
	int unsigned  error_count;

	// idling percentages and the long receiver hold-off
	int unsigned  send_idle_pct;
	int unsigned  recv_idle_pct;
	bit           hold_req;
	int unsigned  hold_left;

	sort_and_dedup_bytes #(
		.ITEMS(SET_CAP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// insert one byte into the predicted set; on end of set queue the sorted words
	function automatic void absorb_byte(input byte_t v, input logic eos);
		int unsigned  pos;
		int unsigned  k;
		bit           dup;
		sorted_word_t w;
		pos = 0;
		while (pos < held_n && held_bytes[pos] < v)
			pos++;
		dup = (pos < held_n) && (held_bytes[pos] == v);
		if (!dup) begin
			if (held_n >= SET_CAP) begin
				// store full, new distinct byte is lost
				held_ovf = 1'b1;
			end else begin
				for (k = held_n; k > pos; k--)
					held_bytes[k] = held_bytes[k-1];
				held_bytes[pos] = v;
				held_n++;
			end
		end
		if (eos) begin
			for (k = 0; k < held_n; k++) begin
				w.sorted_char   = held_bytes[k];
				w.last_char     = (k + 1 == held_n);
				w.overflow_flag = held_ovf;
				expected_words.push_back(w);
			end
			held_n   = 0;
			held_ovf = 1'b0;
		end
	endfunction

	// offer one byte, possibly after some idle cycles; tvalid stays high afterwards
	// so back-to-back words need no second assignment in the same step
	task automatic send_byte(input byte_t v, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tlast  <= eos;
		do
			@(posedge clk);
		while (!s_axis_tready);
		absorb_byte(v, eos);
	endtask

	// sender goes quiet until every predicted word has come out
	task automatic drain_all;
		s_axis_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_set(input byte_t vals [$]);
		int unsigned k;
		for (k = 0; k < vals.size(); k++)
			send_byte(vals[k], k == vals.size() - 1);
	endtask

	// sets of one byte at either end of the range, zero included
	task automatic test_single_byte_sets;
		send_set('{8'h00});
		send_set('{8'hff});
	endtask

	// out-of-order input with repeats, and a repeat as the closing byte
	task automatic test_duplicates;
		send_set('{8'hff, 8'h00, 8'hff, 8'h80});
		send_set('{8'h55, 8'haa, 8'h55});
	endtask

	// eight distinct bytes fill the store, the ninth is dropped and flagged
	task automatic test_overflow;
		send_set('{8'hf0, 8'h0f, 8'h33, 8'hcc, 8'h01, 8'hfe, 8'h7f, 8'h80, 8'h40});
	endtask

	// random sets, mostly within capacity; narrow value windows make repeats likely
	task automatic test_random_sets(input int unsigned n_items);
		int unsigned sent;
		int unsigned set_len;
		int unsigned k;
		bit          narrow;
		byte_t       base;
		byte_t       v;
		sent = 0;
		while (sent < n_items) begin
			set_len = ($urandom_range(7) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
			narrow  = 1'($urandom_range(1));
			base    = byte_t'($urandom_range(255));
			for (k = 0; k < set_len; k++) begin
				v = narrow ? byte_t'(base + $urandom_range(5)) : byte_t'($urandom_range(255));
				send_byte(v, k == set_len - 1);
				sent++;
			end
		end
	endtask

	// receiver stalls for a long stretch while the sender keeps offering sets,
	// so the first set cannot drain and s_axis_tready stays low
	task automatic test_backpressure;
		hold_req = 1'b1;
		send_set('{8'h10, 8'h03, 8'hee, 8'h03});
		send_set('{8'h77, 8'h22, 8'h99, 8'h22});
		send_set('{8'h01, 8'h02, 8'h04, 8'h08});
		drain_all();
	endtask

	// receiver: random tready, overridden by the hold-off counter
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = 200;
		end
		if (hold_left != 0) begin
			hold_left     = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// scoreboard: each accepted word against the oldest prediction
	always @(posedge clk) begin
		sorted_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word: sorted_char %0h", m_axis_tdata);
				error_count++;
			end else begin
				want = expected_words.pop_front();
				if (m_axis_tdata !== want.sorted_char) begin
					$error("sorted_char: expected %0h, actual %0h", want.sorted_char,
						m_axis_tdata);
					error_count++;
				end
				if (m_axis_tlast !== want.last_char) begin
					$error("last_char: expected %0b, actual %0b", want.last_char,
						m_axis_tlast);
					error_count++;
				end
				if (m_axis_tuser !== want.overflow_flag) begin
					$error("overflow_flag: expected %0b, actual %0b", want.overflow_flag,
						m_axis_tuser);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		held_n        = 0;
		held_ovf      = 1'b0;
		error_count   = 0;
		hold_req      = 1'b0;
		hold_left     = 0;
		send_idle_pct = 21;
		recv_idle_pct = 79;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_byte_sets();
		test_duplicates();
		test_overflow();
		test_random_sets(36);
		drain_all();

		send_idle_pct = 79;
		recv_idle_pct = 21;
		test_random_sets(36);
		drain_all();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_sets(36);
		test_backpressure();

		drain_all();
		repeat (16) @(posedge clk);
		if (error_count == 0) begin
			$display("sort_and_dedup_bytes: match");
		end else begin
			$display("sort_and_dedup_bytes: mismatch");
		end
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#5ms;
		$display("sort_and_dedup_bytes: mismatch");
		$finish;
	end

endmodule
